// File: src/linked_list_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Linked list table engine assertion macros
// Shared check macros for the engine; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINKED_LIST_TABLE_ENGINE_DEFINES_SVH
`define LINKED_LIST_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("linked list engine check failed");
// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("linked list engine check failed");
`else
`define LLE_ASSERT_IMP(lbl, ante, cons)
`define LLE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: src/lle_pkg.sv
// ----------------------------------------------------------------------------
// Linked list table engine package
// Command and status codes, item types and sequencer states.
// ----------------------------------------------------------------------------
package lle_pkg;

	localparam int POS_W  = 7;
	localparam int ITEM_W = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_DUMP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [ITEM_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		status_t                  status;
		logic [POS_W-1:0]         position;
		logic signed [ITEM_W-1:0] item_value;
		logic                     last;
	} out_item_t;

	// Strobes from the sequencer to the node memories.
	typedef struct packed {
		logic rd_en;
		logic val_we;
		logic link_we;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_LINK,
		ST_WALK,
		ST_DEL_PREV,
		ST_DEL_FREE,
		ST_REPLY
	} state_t;

	function automatic out_item_t mk_item(status_t st, logic [POS_W-1:0] pos,
			logic signed [ITEM_W-1:0] val, logic lst);
		out_item_t r;
		r.status     = st;
		r.position   = pos;
		r.item_value = val;
		r.last       = lst;
		return r;
	endfunction

endpackage

// File: src/lle_node_mem.sv
// ----------------------------------------------------------------------------
// Linked list node memories
// Value and link arrays with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lle_node_mem #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int IDX_W      = $clog2(CAPACITY),
	localparam int PTR_W      = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lle_pkg::mem_ctl_t             ctl,
	input  logic [PTR_W-1:0]              rd_addr,
	input  logic [PTR_W-1:0]              wr_addr,
	input  logic signed [VALUE_WIDTH-1:0] wr_val,
	input  logic [PTR_W-1:0]              wr_link,
	output logic signed [VALUE_WIDTH-1:0] rd_val,
	output logic [PTR_W-1:0]              rd_link
);
	import lle_pkg::*;

	logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
	logic [PTR_W-1:0]       link_mem [CAPACITY];
	logic [CAPACITY-1:0]    link_set_q;

	logic [VALUE_WIDTH-1:0] rd_val_q;
	logic [PTR_W-1:0]       rd_link_q;
	logic [PTR_W-1:0]       rd_addr_q;
	logic                   rd_set_q;

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;

	assign rd_idx = rd_addr[IDX_W-1:0];
	assign wr_idx = wr_addr[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[wr_idx] <= wr_val;
		end
		if (ctl.link_we) begin
			link_mem[wr_idx] <= wr_link;
		end
		if (ctl.rd_en) begin
			rd_val_q  <= val_mem[rd_idx];
			rd_link_q <= link_mem[rd_idx];
			rd_set_q  <= link_set_q[rd_idx];
			rd_addr_q <= rd_addr;
		end
	end

	// A link never written still holds its reset value: the next node in index
	// order, where one past the last node is the none code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_set_q <= '0;
		end else if (ctl.link_we) begin
			link_set_q[wr_idx] <= 1'b1;
		end
	end

	assign rd_val  = $signed(rd_val_q);
	assign rd_link = rd_set_q ? rd_link_q : PTR_W'(rd_addr_q + 1'b1);

endmodule

// File: src/lle_seq.sv
// ----------------------------------------------------------------------------
// Linked list sequencer
// Holds the list pointers and walks the node memories for each command.
// ----------------------------------------------------------------------------
module lle_seq #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int PTR_W      = $clog2(CAPACITY + 1),
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  lle_pkg::in_item_t             req,
	output logic                          res_valid,
	input  logic                          res_ready,
	output lle_pkg::out_item_t            res,
	output lle_pkg::mem_ctl_t             mem_ctl,
	output logic [PTR_W-1:0]              rd_addr,
	output logic [PTR_W-1:0]              wr_addr,
	output logic signed [VALUE_WIDTH-1:0] wr_val,
	output logic [PTR_W-1:0]              wr_link,
	input  logic signed [VALUE_WIDTH-1:0] rd_val,
	input  logic [PTR_W-1:0]              rd_link
);
	import lle_pkg::*;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

	state_t state_q, state_d;

	logic [PTR_W-1:0] head_q, tail_q, free_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] cur_q, prev_q, next_q;
	logic [CNT_W-1:0] steps_q;
	cmd_t             cmd_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	out_item_t        reply_q;

	logic head_ok, tail_ok, free_ok, prev_ok, link_ok;
	logic at_limit, hit, fin, list_full;
	logic [PTR_W-1:0] new_head;
	logic [POS_W-1:0] pos_now;

	assign head_ok   = head_q < NIL;
	assign tail_ok   = tail_q < NIL;
	assign free_ok   = free_q < NIL;
	assign prev_ok   = prev_q < NIL;
	assign link_ok   = rd_link < NIL;
	assign at_limit  = steps_q == CNT_W'(CAPACITY - 1);
	assign hit       = rd_val == value_q;
	assign fin       = !link_ok || at_limit;
	assign list_full = (count_q >= CNT_W'(CAPACITY)) || !free_ok;
	assign new_head  = prev_ok ? head_q : next_q;
	assign pos_now   = POS_W'(steps_q + 1'b1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.cmd == CMD_INSERT) begin
						state_d = list_full ? ST_REPLY : ST_INS_RD;
					end else begin
						state_d = head_ok ? ST_WALK : ST_REPLY;
					end
				end
			end
			ST_INS_RD:   state_d = (head_ok && tail_ok) ? ST_INS_LINK : ST_REPLY;
			ST_INS_LINK: state_d = ST_REPLY;
			ST_WALK: begin
				if (cmd_q == CMD_DUMP) begin
					if (res_ready && fin) begin
						state_d = ST_IDLE;
					end
				end else if (hit) begin
					if (cmd_q == CMD_SEARCH) begin
						state_d = ST_REPLY;
					end else begin
						state_d = prev_ok ? ST_DEL_PREV : ST_DEL_FREE;
					end
				end else if (fin) begin
					state_d = ST_REPLY;
				end
			end
			ST_DEL_PREV: state_d = ST_DEL_FREE;
			ST_DEL_FREE: state_d = ST_REPLY;
			ST_REPLY: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory strobes. The sequencer never reads and writes the
	// memories in the same cycle, so no forwarding path is needed.
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		res       = reply_q;
		mem_ctl   = '0;
		rd_addr   = cur_q;
		wr_addr   = cur_q;
		wr_val    = value_q;
		wr_link   = NIL;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.cmd == CMD_INSERT) begin
						mem_ctl.rd_en = !list_full;
						rd_addr       = free_q;
					end else begin
						mem_ctl.rd_en = head_ok;
						rd_addr       = head_q;
					end
				end
			end
			ST_INS_RD: begin
				mem_ctl.val_we  = 1'b1;
				mem_ctl.link_we = 1'b1;
			end
			ST_INS_LINK: begin
				mem_ctl.link_we = 1'b1;
				wr_addr         = tail_q;
				wr_link         = cur_q;
			end
			ST_WALK: begin
				rd_addr = rd_link;
				if (cmd_q == CMD_DUMP) begin
					res_valid     = 1'b1;
					res           = mk_item(STAT_OK, pos_now, ITEM_W'(rd_val), fin);
					mem_ctl.rd_en = res_ready && !fin;
				end else begin
					mem_ctl.rd_en = !hit && !fin;
				end
			end
			ST_DEL_PREV: begin
				mem_ctl.link_we = 1'b1;
				wr_addr         = prev_q;
				wr_link         = next_q;
			end
			ST_DEL_FREE: begin
				mem_ctl.link_we = 1'b1;
				wr_link         = free_ok ? free_q : NIL;
			end
			ST_REPLY: begin
				res_valid = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// List pointers and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= NIL;
			tail_q  <= NIL;
			free_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INS_RD: begin
					free_q <= rd_link;
					if (!(head_ok && tail_ok)) begin
						head_q  <= cur_q;
						tail_q  <= cur_q;
						count_q <= count_q + 1'b1;
					end
				end
				ST_INS_LINK: begin
					tail_q  <= cur_q;
					count_q <= count_q + 1'b1;
				end
				ST_DEL_FREE: begin
					free_q <= cur_q;
					if (count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
					if (new_head >= NIL) begin
						head_q <= NIL;
						tail_q <= NIL;
					end else begin
						head_q <= new_head;
						if (tail_q == cur_q) begin
							tail_q <= prev_ok ? prev_q : NIL;
						end
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd_q   <= req.cmd;
					value_q <= VALUE_WIDTH'(req.value);
					cur_q   <= (req.cmd == CMD_INSERT) ? free_q : head_q;
					prev_q  <= NIL;
					steps_q <= '0;
					if (req.cmd == CMD_INSERT) begin
						reply_q <= mk_item(STAT_FULL, '0, '0, 1'b1);
					end else begin
						reply_q <= mk_item(STAT_EMPTY, '0, '0, 1'b1);
					end
				end
			end
			ST_INS_RD, ST_INS_LINK, ST_DEL_FREE: begin
				reply_q <= mk_item(STAT_OK, '0, '0, 1'b1);
			end
			ST_WALK: begin
				if (cmd_q == CMD_DUMP) begin
					if (res_ready && !fin) begin
						cur_q   <= rd_link;
						steps_q <= steps_q + 1'b1;
					end
				end else if (hit) begin
					next_q  <= rd_link;
					reply_q <= mk_item(STAT_OK, pos_now, ITEM_W'(rd_val), 1'b1);
				end else if (fin) begin
					reply_q <= mk_item(STAT_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rd_link;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

endmodule

// File: src/linked_list_table_engine.sv
// An insert writes the node in ST_INS_RD, links the old tail in ST_INS_LINK, then answers
// from ST_REPLY (an empty list skips ST_INS_LINK, a full one goes straight to ST_REPLY);
// search and delete walk one node per cycle, then delete relinks in ST_DEL_PREV and ST_DEL_FREE;
// dump gives its first item once the head read is back, then one per cycle as fast as the result
// side takes them. One command at a time; the node memory's single read port sets the walk rate.
// Reset (arst_n low) empties the list at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Linked list table engine
// Bounded singly linked list with a free list, kept in node memories.
// ----------------------------------------------------------------------------
`include "linked_list_table_engine_defines.svh"

module linked_list_table_engine #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  lle_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output lle_pkg::out_item_t rsp
);
	import lle_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY + 1);

	// Sequencer result side, before the output register.
	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	// Node memory port.
	mem_ctl_t                      mem_ctl;
	logic [PTR_W-1:0]              rd_addr;
	logic [PTR_W-1:0]              wr_addr;
	logic signed [VALUE_WIDTH-1:0] wr_val;
	logic [PTR_W-1:0]              wr_link;
	logic signed [VALUE_WIDTH-1:0] rd_val;
	logic [PTR_W-1:0]              rd_link;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	// The sequencer owns the head, tail and free pointers plus the node count,
	// and steps through the list one node per cycle, a dump only while results are taken: the
	// link read back from the memory is the address of the next read.
	lle_seq #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_val    (wr_val),
		.wr_link   (wr_link),
		.rd_val    (rd_val),
		.rd_link   (rd_link)
	);

	// Node values and links. Unwritten links read back as the initial free
	// chain, so the free list exists from reset without a sweep.
	lle_node_mem #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_val  (wr_val),
		.wr_link (wr_link),
		.rd_val  (rd_val),
		.rd_link (rd_link)
	);

	// The output register takes a new item whenever it is empty or its item is
	// leaving in this cycle, so a dump streams one item per cycle while rsp_ready is high.
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A command is only taken while the sequencer has no result to give.
	`LLE_ASSERT_IMP(a_accept_quiet, req_valid && req_ready, !res_valid)
	// Once the last result of a command leaves, the sequencer is free again.
	`LLE_ASSERT_NXT(a_last_frees, res_valid && res_ready && res.last, req_ready)
	// Positions never run past the list capacity.
	`LLE_ASSERT_IMP(a_pos_range, res_valid, res.position <= POS_W'(CAPACITY))
	// Any status other than ok is a single, final result with no position.
	`LLE_ASSERT_IMP(a_err_single, res_valid && res.status != STAT_OK,
		res.last && res.position == '0)

endmodule
